/* src/dmhd_pkg.sv */
package dmhd_pkg;
    localparam int ARM_W     = 24;
    localparam int ARMS      = 6;
    localparam int HASH_MOD  = 1021;
    localparam int ENTRIES   = 1024;
    localparam int HASH_W    = $clog2(HASH_MOD);
    localparam int ENT_W     = $clog2(ENTRIES);
    localparam int PTR_W     = $clog2(ENTRIES + 1);
    localparam int ROW_W     = ARM_W * ARMS;
    // 2^HASH_W folds to FOLD_K modulo HASH_MOD
    localparam int FOLD_K    = (1 << HASH_W) - HASH_MOD;

    typedef logic [ARM_W-1:0] t_arm;
    typedef t_arm [ARMS-1:0]  t_ring;
    typedef logic [2:0]       t_res;

    localparam t_res RES_TWIN = 3'b001;
    localparam t_res RES_INS  = 3'b010;
    localparam t_res RES_FULL = 3'b100;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_HEAD, ST_HEADW, ST_ROW, ST_ROWW,
        ST_CMP, ST_TAIL, ST_TAILW, ST_WRITE, ST_LINK, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic clr_step;
        logic head_rd;
        logic head_take;
        logic row_take;
        logic tail_take;
        logic commit;
        logic link_fix;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic ptr_ok;
        logic alike;
        logic full;
        logic head_empty;
    } t_sts;

    function automatic logic rings_alike(t_ring a, t_ring b);
        logic hit, f, r;
        hit = 1'b0;
        for (int j = 0; j < ARMS; j++) begin
            f = 1'b1;
            r = 1'b1;
            for (int k = 0; k < ARMS; k++) begin
                if (a[k] != b[(j + k) % ARMS]) f = 1'b0;
                if (a[k] != b[(j - k + ARMS) % ARMS]) r = 1'b0;
            end
            hit = hit | f | r;
        end
        return hit;
    endfunction
endpackage

/* src/dmhd_if.sv */
interface dmhd_in_if;
    import dmhd_pkg::*;
    logic valid;
    logic ready;
    t_arm arm0, arm1, arm2, arm3, arm4, arm5;
    modport source (output valid, arm0, arm1, arm2, arm3, arm4, arm5, input ready);
    modport sink (input valid, arm0, arm1, arm2, arm3, arm4, arm5, output ready);
endinterface

interface dmhd_out_if;
    logic valid;
    logic ready;
    logic twin_found;
    logic inserted;
    logic table_full;
    modport source (output valid, twin_found, inserted, table_full, input ready);
    modport sink (input valid, twin_found, inserted, table_full, output ready);
endinterface

/* src/dmhd_ram.sv */
module dmhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/dmhd_dp.sv */
module dmhd_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dmhd_pkg::t_cmd  i_cmd,
    input  dmhd_pkg::t_ring i_ring,
    output dmhd_pkg::t_sts  o_sts
);
    import dmhd_pkg::*;

    t_ring              r_item;
    logic [HASH_W-1:0]  r_resid [ARMS];
    logic [HASH_W-1:0]  r_sum, r_prod, r_hash, r_clr;
    logic [2:0]         r_idx;
    logic [PTR_W-1:0]   r_ptr, r_tail, r_count;
    logic [ENT_W:0]     r_steps;
    logic               r_clr_done, r_alike, r_empty;

    logic [HASH_W-1:0]   rs_now, sum_nx, prod_nx, hash_nx;
    logic [2*HASH_W-1:0] prod_full;
    logic                head_we, link_we;
    logic [HASH_W-1:0]   head_wa;
    logic [PTR_W-1:0]    head_wd, head_rdat, tail_rdat, link_rdat, link_wd, next_cnt;
    logic [ENT_W-1:0]    link_wa, ent_ra;
    t_ring               row_rdat;

    function automatic logic [HASH_W-1:0] mod_sub(logic [HASH_W:0] x);
        return (x >= (HASH_W+1)'(HASH_MOD)) ? HASH_W'(x - (HASH_W+1)'(HASH_MOD)) : HASH_W'(x);
    endfunction

    function automatic logic [HASH_W-1:0] mod_add(logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
        return mod_sub((HASH_W+1)'(a) + (HASH_W+1)'(b));
    endfunction

    function automatic logic [HASH_W-1:0] fold_arm(t_arm a);
        logic [HASH_W+5:0] f1;
        logic [HASH_W:0]   f2;
        f1 = (HASH_W+6)'(a[ARM_W-1:HASH_W]) * (HASH_W+6)'(FOLD_K)
             + (HASH_W+6)'(a[HASH_W-1:0]);
        f2 = (HASH_W+1)'(f1[HASH_W+5:HASH_W]) * (HASH_W+1)'(FOLD_K)
             + (HASH_W+1)'(f1[HASH_W-1:0]);
        return mod_sub(f2);
    endfunction

    function automatic logic [HASH_W-1:0] fold_prod(logic [2*HASH_W-1:0] x);
        logic [HASH_W+1:0] f1;
        logic [HASH_W:0]   f2;
        f1 = (HASH_W+2)'(x[2*HASH_W-1:HASH_W]) * (HASH_W+2)'(FOLD_K)
             + (HASH_W+2)'(x[HASH_W-1:0]);
        f2 = (HASH_W+1)'(f1[HASH_W+1:HASH_W]) * (HASH_W+1)'(FOLD_K)
             + (HASH_W+1)'(f1[HASH_W-1:0]);
        return mod_sub(f2);
    endfunction

    // arm residues taken at load, one sum and product step per cycle
    assign rs_now    = r_resid[r_idx];
    assign sum_nx    = mod_add(r_sum, rs_now);
    assign prod_full = (2*HASH_W)'(r_prod) * (2*HASH_W)'(rs_now);
    assign prod_nx   = fold_prod(prod_full);
    assign hash_nx   = mod_add(r_sum, r_prod);
    assign next_cnt  = r_count + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_count    <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + HASH_W'(1);
                if (r_clr == HASH_W'(HASH_MOD - 1)) r_clr_done <= 1'b1;
            end
            if (i_cmd.commit) r_count <= next_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_ring;
            for (int k = 0; k < ARMS; k++) r_resid[k] <= fold_arm(i_ring[k]);
            r_sum  <= '0;
            r_prod <= HASH_W'(1);
            r_idx  <= '0;
        end
        if (i_cmd.hash_step) begin
            r_sum  <= sum_nx;
            r_prod <= prod_nx;
            if (r_idx != 3'(ARMS - 1)) r_idx <= r_idx + 3'd1;
        end
        if (i_cmd.head_rd) r_hash <= hash_nx;
        if (i_cmd.head_take) begin
            r_ptr   <= head_rdat;
            r_steps <= '0;
            r_empty <= (head_rdat == '0);
        end
        if (i_cmd.row_take) begin
            r_ptr   <= link_rdat;
            r_steps <= r_steps + (ENT_W+1)'(1);
            r_alike <= rings_alike(row_rdat, r_item);
        end
        if (i_cmd.tail_take) r_tail <= tail_rdat;
    end

    // bucket heads: zero is an empty chain, swept to zero after reset
    assign head_we = i_cmd.clr_step | (i_cmd.commit & r_empty);
    assign head_wa = i_cmd.clr_step ? r_clr : r_hash;
    assign head_wd = i_cmd.clr_step ? '0 : next_cnt;

    dmhd_ram #(.WIDTH(PTR_W), .DEPTH(HASH_MOD)) u_head (
        .i_clk, .i_we(head_we), .i_waddr(head_wa),
        .i_wdata(head_wd), .i_raddr(hash_nx), .o_rdata(head_rdat)
    );

    dmhd_ram #(.WIDTH(PTR_W), .DEPTH(HASH_MOD)) u_tail (
        .i_clk, .i_we(i_cmd.commit), .i_waddr(r_hash),
        .i_wdata(next_cnt), .i_raddr(r_hash), .o_rdata(tail_rdat)
    );

    // new entry ends its chain; old tail is linked the cycle after
    assign ent_ra  = ENT_W'(r_ptr - PTR_W'(1));
    assign link_we = i_cmd.commit | i_cmd.link_fix;
    assign link_wa = i_cmd.link_fix ? ENT_W'(r_tail - PTR_W'(1)) : ENT_W'(r_count);
    assign link_wd = i_cmd.link_fix ? r_count : '0;

    dmhd_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_link (
        .i_clk, .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(ent_ra), .o_rdata(link_rdat)
    );

    dmhd_ram #(.WIDTH(ROW_W), .DEPTH(ENTRIES)) u_arms (
        .i_clk, .i_we(i_cmd.commit), .i_waddr(ENT_W'(r_count)), .i_wdata(r_item),
        .i_raddr(ent_ra), .o_rdata(row_rdat)
    );

    assign o_sts.clr_done   = r_clr_done;
    assign o_sts.hash_done  = (r_idx == 3'(ARMS - 1));
    assign o_sts.ptr_ok     = (r_ptr != '0) && (r_ptr <= PTR_W'(ENTRIES))
                              && (r_steps < (ENT_W+1)'(ENTRIES));
    assign o_sts.alike      = r_alike;
    assign o_sts.full       = (r_count >= PTR_W'(ENTRIES));
    assign o_sts.head_empty = r_empty;

    a_commit_room: assert property (@(posedge i_clk)
        !i_rst_n || !i_cmd.commit || (r_count < PTR_W'(ENTRIES)))
        else $error("commit past capacity");
    a_clear_range: assert property (@(posedge i_clk)
        !i_rst_n || !i_cmd.clr_step || (r_clr < HASH_W'(HASH_MOD)))
        else $error("clear sweep out of range");
    a_link_tail: assert property (@(posedge i_clk)
        !i_rst_n || !i_cmd.link_fix || (r_tail != '0))
        else $error("tail link with no tail");
endmodule

/* src/dmhd_ctrl.sv */
module dmhd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_twin,
    output logic           o_ins,
    output logic           o_full,
    input  dmhd_pkg::t_sts i_sts,
    output dmhd_pkg::t_cmd o_cmd
);
    import dmhd_pkg::*;

    t_state r_state, n_state;
    t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
                else o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_HASH;
                end
            end
            ST_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_done) n_state = ST_HEAD;
            end
            ST_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state = ST_HEADW;
            end
            ST_HEADW: begin
                o_cmd.head_take = 1'b1;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                if (i_sts.ptr_ok) n_state = ST_ROWW;
                else if (i_sts.full) begin
                    n_res = RES_FULL; n_state = ST_OUT;
                end else n_state = i_sts.head_empty ? ST_WRITE : ST_TAIL;
            end
            ST_ROWW: begin
                o_cmd.row_take = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (i_sts.alike) begin
                    n_res = RES_TWIN; n_state = ST_OUT;
                end else n_state = ST_ROW;
            end
            ST_TAIL: n_state = ST_TAILW;
            ST_TAILW: begin
                o_cmd.tail_take = 1'b1;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.commit = 1'b1;
                n_res = RES_INS;
                n_state = i_sts.head_empty ? ST_OUT : ST_LINK;
            end
            ST_LINK: begin
                o_cmd.link_fix = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_twin = (r_res == RES_TWIN);
    assign o_ins  = (r_res == RES_INS);
    assign o_full = (r_res == RES_FULL);

    a_no_ready_busy: assert property (@(posedge i_clk)
        !i_rst_n || !(o_in_ready && o_out_valid))
        else $error("ready while result pending");
    a_flags_onehot: assert property (@(posedge i_clk)
        !i_rst_n || !o_out_valid || $onehot(r_res))
        else $error("result flags not one-hot");
    a_no_ready_clear: assert property (@(posedge i_clk)
        !i_rst_n || (r_state != ST_CLEAR) || !o_in_ready)
        else $error("ready during clear");
endmodule

/* src/dihedral_match_hash_dedup.sv */
// channel | dir | word
// s_in    | in  | arm0..arm5, 24 bits each
// m_out   | out | twin_found, inserted, table_full
// After reset a sweep clears the bucket heads; the first word is taken once the sweep is done.
// Per word: accept, hash, head read, then a row read and compare per chain entry walked.
// Insert: a write into an empty bucket, or a tail read, write and tail link when the old chain tail must be linked.
// Result held until taken; no new word accepted until then.
module dihedral_match_hash_dedup (
    input  logic i_clk,
    input  logic i_rst_n,
    dmhd_in_if.sink    s_in,
    dmhd_out_if.source m_out
);
    import dmhd_pkg::*;

    t_cmd  cmd;
    t_sts  sts;
    t_ring ring;

    assign ring = {s_in.arm5, s_in.arm4, s_in.arm3, s_in.arm2, s_in.arm1, s_in.arm0};

    dmhd_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .o_out_valid(m_out.valid), .i_out_ready(m_out.ready),
        .o_twin(m_out.twin_found), .o_ins(m_out.inserted), .o_full(m_out.table_full),
        .i_sts(sts), .o_cmd(cmd)
    );

    dmhd_dp u_dp (.i_clk, .i_rst_n, .i_cmd(cmd), .i_ring(ring), .o_sts(sts));
endmodule
